### hw/rtl/hsc_pkg.sv
// Package for the streaming host name syntax checker.
// Request payload types, character codes, register indexes and limits.
// No dependencies.
`timescale 1ns / 1ps

package hsc_pkg;

    // Input request: one character of the name
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_req;

    // Result request: verdict so far, plus end-of-name flag
    typedef struct packed {
        logic valid_res;
        logic done_res;
    } t_out_req;

    localparam int unsigned LABEL_CNT_W = 7;
    localparam int unsigned NAME_CNT_W  = 8;
    localparam int unsigned MAX_LABEL_W = 6;
    localparam int unsigned MAX_NAME_W  = 8;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [MAX_LABEL_W-1:0] MAX_LABEL_RESET = 6'd63;
    localparam logic [MAX_NAME_W-1:0]  NAME_LIMIT_TOP  = 8'd253;

    // Register indexes on the configuration port
    localparam logic CFG_MAX_LABEL = 1'b0;
    localparam logic CFG_MAX_NAME  = 1'b1;

    // Character codes
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UC_LO  = 8'h41;
    localparam logic [7:0] CH_UC_HI  = 8'h5A;
    localparam logic [7:0] CH_LC_LO  = 8'h61;
    localparam logic [7:0] CH_LC_HI  = 8'h7A;

endpackage

### hw/rtl/hostname_syntax_checker_core.sv
// Host name syntax checker: one character per request, running verdict per request.
// Result path: input register, then result register. Throughput: one character
// per cycle unless stalled; label/name counters update in one pass.
// Reset (synchronous, active low) clears the pipeline, name state and sets the
// limits to 63 (label) and 253 (name). Depends on hsc_pkg.
`timescale 1ns / 1ps

module hostname_syntax_checker_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_valid,
    input  hsc_pkg::t_in_req                i_data,
    output logic                            o_stall,
    // result channel
    output logic                            o_valid,
    output hsc_pkg::t_out_req               o_data,
    input  logic                            i_stall,
    // configuration
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                                r_in_vld;
    hsc_pkg::t_in_req                    r_in;
    logic                                r_out_vld;
    hsc_pkg::t_out_req                   r_out;
    hsc_pkg::t_out_req                   n_out;

    logic [hsc_pkg::MAX_LABEL_W-1:0]     r_max_label;
    logic [hsc_pkg::MAX_NAME_W-1:0]      r_max_name;

    logic [hsc_pkg::LABEL_CNT_W-1:0]     r_label_cnt;
    logic [hsc_pkg::LABEL_CNT_W-1:0]     n_label_cnt;
    logic [hsc_pkg::NAME_CNT_W-1:0]      r_name_cnt;
    logic [hsc_pkg::NAME_CNT_W-1:0]      n_name_cnt;
    logic                                r_prev_hyp;
    logic                                n_prev_hyp;
    logic                                r_failed;
    logic                                n_failed;

    logic                                adv;
    logic                                in_acc;
    logic                                is_dot;
    logic                                is_hyp;
    logic                                allowed;
    logic [hsc_pkg::NAME_CNT_W-1:0]      name_lim;
    logic [hsc_pkg::NAME_CNT_W:0]        next_name;
    logic [hsc_pkg::LABEL_CNT_W-1:0]     next_label;
    logic                                bad_dot;
    logic                                bad_label;
    logic                                bad_name;
    logic                                fail_now;

    // Stage 1 moves on when the result register is free or being drained.
    assign adv     = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !adv;
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    always_comb begin
        is_dot  = (r_in.ch == hsc_pkg::CH_DOT);
        is_hyp  = (r_in.ch == hsc_pkg::CH_HYPHEN);
        allowed = (r_in.ch >= hsc_pkg::CH_LC_LO && r_in.ch <= hsc_pkg::CH_LC_HI)
               || (r_in.ch >= hsc_pkg::CH_UC_LO && r_in.ch <= hsc_pkg::CH_UC_HI)
               || (r_in.ch >= hsc_pkg::CH_DIG_LO && r_in.ch <= hsc_pkg::CH_DIG_HI)
               || is_dot || is_hyp;

        name_lim   = (r_max_name > hsc_pkg::NAME_LIMIT_TOP) ? hsc_pkg::NAME_LIMIT_TOP
                                                             : r_max_name;
        next_name  = {1'b0, r_name_cnt} + 9'd1;
        next_label = r_label_cnt + 7'd1;

        bad_dot   = is_dot && (r_prev_hyp || (r_label_cnt == '0));
        bad_label = !is_dot && (((r_label_cnt == '0) && is_hyp)
                             || (next_label > {1'b0, r_max_label}));
        // one trailing dot may sit just past the name limit
        bad_name  = (next_name > {1'b0, name_lim})
                 && ((next_name != ({1'b0, name_lim} + 9'd1)) || !is_dot);
        fail_now  = !allowed || bad_dot || bad_label || bad_name;

        n_failed    = r_failed || fail_now;
        n_label_cnt = r_label_cnt;
        n_name_cnt  = r_name_cnt;
        n_prev_hyp  = r_prev_hyp;
        if (!n_failed) begin
            n_label_cnt = is_dot ? '0 : next_label;
            n_name_cnt  = next_name[hsc_pkg::NAME_CNT_W-1:0];
            n_prev_hyp  = is_hyp;
        end

        n_out.valid_res = !n_failed;
        n_out.done_res  = r_in.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_label <= hsc_pkg::MAX_LABEL_RESET;
            r_max_name  <= hsc_pkg::NAME_LIMIT_TOP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hsc_pkg::CFG_MAX_LABEL: r_max_label <= i_cfg_data[hsc_pkg::MAX_LABEL_W-1:0];
                hsc_pkg::CFG_MAX_NAME:  r_max_name  <= i_cfg_data[hsc_pkg::MAX_NAME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // Name state; cleared after the last character of each name
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_cnt <= '0;
            r_name_cnt  <= '0;
            r_prev_hyp  <= 1'b0;
            r_failed    <= 1'b0;
        end else if (adv) begin
            if (r_in.last) begin
                r_label_cnt <= '0;
                r_name_cnt  <= '0;
                r_prev_hyp  <= 1'b0;
                r_failed    <= 1'b0;
            end else begin
                r_label_cnt <= n_label_cnt;
                r_name_cnt  <= n_name_cnt;
                r_prev_hyp  <= n_prev_hyp;
                r_failed    <= n_failed;
            end
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_vld && r_out_vld && i_stall))
        else $error("input stalled while pipeline can drain");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.last) |=> ((r_name_cnt == '0) && (r_label_cnt == '0) && !r_failed
                                && !r_prev_hyp))
        else $error("name state not cleared after last character");

    a_sticky_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_failed) |=> !r_out.valid_res)
        else $error("valid result reported after an error in the name");

    a_name_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_name_cnt} <= ({1'b0, hsc_pkg::NAME_LIMIT_TOP} + 9'd1))
        else $error("name count beyond limit plus trailing dot");

    a_done_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (r_out.done_res == $past(r_in.last)))
        else $error("done flag does not match last flag");

endmodule

### tb/sv/hostname_syntax_checker_core_tb.sv
// Self-checking testbench for hostname_syntax_checker_core: streams host names,
// predicts the running verdict per character and checks every result in order.
// Depends on hsc_pkg and the core.
`timescale 1ns / 1ps

module hostname_syntax_checker_core_tb;

    localparam int unsigned STALL_PCT  = 26;
    localparam int unsigned HANG_LIMIT = 2000;

    typedef struct {
        hsc_pkg::t_in_req req;
        bit               hold;    // sender waits for all results before this request
    } t_pending_char;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    hsc_pkg::t_in_req               i_data = '0;
    logic                           o_stall;
    logic                           o_valid;
    hsc_pkg::t_out_req              o_data;
    logic                           i_stall = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic                           i_cfg_idx = hsc_pkg::CFG_MAX_LABEL;
    logic [hsc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    t_pending_char     char_q[$];
    hsc_pkg::t_out_req verdict_q[$];

    // predictor copy of limits and name state
    logic [hsc_pkg::MAX_LABEL_W-1:0] cfg_label_max = hsc_pkg::MAX_LABEL_RESET;
    logic [hsc_pkg::MAX_NAME_W-1:0]  cfg_name_max = hsc_pkg::NAME_LIMIT_TOP;
    logic [hsc_pkg::LABEL_CNT_W-1:0] label_len = '0;
    logic [hsc_pkg::NAME_CNT_W-1:0]  name_len = '0;
    logic                            after_hyphen = 1'b0;
    logic                            name_failed = 1'b0;

    int n_sent = 0;
    int n_queued = 0;
    int n_names = 0;
    int n_settings = 1;
    int n_results = 0;
    int n_errors = 0;
    int hang_cnt = 0;

    wire quiet = (n_sent >= 200) && (n_sent < 330);

    hostname_syntax_checker_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic hsc_pkg::t_out_req verdict_for(hsc_pkg::t_in_req c);
        hsc_pkg::t_out_req v;
        int unsigned       lim;
        int unsigned       nl;
        int unsigned       nn;
        bit                bad;
        lim = (cfg_name_max > hsc_pkg::NAME_LIMIT_TOP) ? hsc_pkg::NAME_LIMIT_TOP
                                                       : cfg_name_max;
        if (!name_failed) begin
            if (!((c.ch >= hsc_pkg::CH_LC_LO && c.ch <= hsc_pkg::CH_LC_HI) ||
                  (c.ch >= hsc_pkg::CH_UC_LO && c.ch <= hsc_pkg::CH_UC_HI) ||
                  (c.ch >= hsc_pkg::CH_DIG_LO && c.ch <= hsc_pkg::CH_DIG_HI) ||
                  c.ch == hsc_pkg::CH_HYPHEN || c.ch == hsc_pkg::CH_DOT)) begin
                name_failed = 1'b1;
            end else begin
                bad = 1'b0;
                nn = name_len + 1;
                if (c.ch == hsc_pkg::CH_DOT) begin
                    if (after_hyphen || label_len == 0) bad = 1'b1;
                    nl = 0;
                end else begin
                    if (label_len == 0 && c.ch == hsc_pkg::CH_HYPHEN) bad = 1'b1;
                    nl = label_len + 1;
                    if (nl > cfg_label_max) bad = 1'b1;
                end
                // one trailing dot may go one past the name limit
                if (nn > lim && (nn != lim + 1 || c.ch != hsc_pkg::CH_DOT)) bad = 1'b1;
                if (bad) begin
                    name_failed = 1'b1;
                end else begin
                    label_len = nl[hsc_pkg::LABEL_CNT_W-1:0];
                    name_len = nn[hsc_pkg::NAME_CNT_W-1:0];
                    after_hyphen = (c.ch == hsc_pkg::CH_HYPHEN);
                end
            end
        end
        v.valid_res = !name_failed;
        v.done_res = c.last;
        if (c.last) begin
            label_len = '0;
            name_len = '0;
            after_hyphen = 1'b0;
            name_failed = 1'b0;
        end
        return v;
    endfunction

    function automatic logic [7:0] alnum();
        case ($urandom_range(0, 2))
            0: return hsc_pkg::CH_DIG_LO + 8'($urandom_range(0, 9));
            1: return hsc_pkg::CH_UC_LO + 8'($urandom_range(0, 25));
            default: return hsc_pkg::CH_LC_LO + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic bit busy();
        return char_q.size() != 0 || i_valid || verdict_q.size() != 0;
    endfunction

    task automatic push_chars(logic [7:0] s[$], bit hold);
        t_pending_char p;
        foreach (s[i]) begin
            p.req.ch = s[i];
            p.req.last = (i == s.size() - 1);
            p.hold = hold && (i == 0);
            char_q.push_back(p);
        end
        n_queued += s.size();
        n_names++;
    endtask

    task automatic push_text(string t);
        logic [7:0] s[$];
        for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
        push_chars(s, 1'b0);
    endtask

    // Mostly well-formed names with random content, some deliberately broken
    task automatic queue_name(bit hold);
        logic [7:0]  s[$];
        int unsigned nlab;
        int unsigned len;
        int unsigned cap;
        int unsigned r;
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 4)) s.push_back(8'($urandom_range(0, 255)));
        end else begin
            cap = (cfg_label_max == 0) ? 1 : cfg_label_max;
            nlab = $urandom_range(1, 4);
            for (int l = 0; l < nlab; l++) begin
                if (l != 0) begin
                    if ($urandom_range(0, 99) < 8) s.push_back(hsc_pkg::CH_HYPHEN);
                    s.push_back(hsc_pkg::CH_DOT);
                    if ($urandom_range(0, 99) < 5) s.push_back(hsc_pkg::CH_DOT);
                end
                if ($urandom_range(0, 99) < 8) s.push_back(hsc_pkg::CH_HYPHEN);
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(1, cap + 1);
                else
                    len = $urandom_range(1, (cap + 1 < 8) ? cap + 1 : 8);
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                        s.push_back(8'($urandom_range(0, 255)));
                    else if (r < 18 && k != 0 && k != len - 1)
                        s.push_back(hsc_pkg::CH_HYPHEN);
                    else
                        s.push_back(alnum());
                end
            end
            r = $urandom_range(0, 99);
            if (r < 20)
                s.push_back(hsc_pkg::CH_DOT);
            else if (r < 28)
                s.push_back(hsc_pkg::CH_HYPHEN);
        end
        push_chars(s, hold);
    endtask

    task automatic queue_random(int n);
        int target;
        int mid;
        bit held;
        bit hold;
        target = n_queued + n;
        mid = n_queued + n / 2;
        held = 1'b0;
        while (n_queued < target) begin
            hold = !held && n_queued >= mid;
            queue_name(hold);
            if (hold) held = 1'b1;
        end
    endtask

    // Limits change only with the core drained
    task automatic set_limits(logic [7:0] lbl, logic [7:0] nm);
        while (busy()) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= hsc_pkg::CFG_MAX_LABEL;
        i_cfg_data <= lbl;
        cfg_label_max = lbl[hsc_pkg::MAX_LABEL_W-1:0];
        @(posedge i_clk);
        i_cfg_idx <= hsc_pkg::CFG_MAX_NAME;
        i_cfg_data <= nm;
        cfg_name_max = nm;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Sender
    always @(posedge i_clk) begin
        bit ready;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            ready = char_q.size() != 0
                    && !(char_q[0].hold && (i_valid || verdict_q.size() != 0))
                    && (quiet || $urandom_range(0, 99) >= STALL_PCT);
            if (ready) begin
                i_valid <= 1'b1;
                i_data <= char_q[0].req;
                void'(char_q.pop_front());
                n_sent <= n_sent + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks results, then records newly accepted characters
    always @(posedge i_clk) begin
        hsc_pkg::t_out_req want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (verdict_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, got valid=%0b done=%0b",
                             $time, o_data.valid_res, o_data.done_res);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_data.valid_res !== want.valid_res) begin
                        n_errors++;
                        $display("%0t: valid_res mismatch, expected %0b, got %0b",
                                 $time, want.valid_res, o_data.valid_res);
                    end
                    if (o_data.done_res !== want.done_res) begin
                        n_errors++;
                        $display("%0t: done_res mismatch, expected %0b, got %0b",
                                 $time, want.done_res, o_data.done_res);
                    end
                end
            end
            if (i_valid && !o_stall) verdict_q.push_back(verdict_for(i_data));
            i_stall <= !quiet && ($urandom_range(0, 99) < STALL_PCT);
        end
    end

    // Hang detection: no request moving on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            hang_cnt <= 0;
        end else if (hang_cnt >= HANG_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time, verdict_q.size());
            $display("FAILED: results differ");
            $finish;
        end else begin
            hang_cnt <= hang_cnt + 1;
        end
    end

    initial begin
        logic [7:0] raw[$];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed names under reset limits
        push_text("a9Z.b-c");
        push_text("-x");
        push_text("a-.c");
        push_text("a..");
        push_text(".");
        push_text("x-");
        raw.push_back(8'h00);
        push_chars(raw, 1'b0);
        raw = {};
        raw.push_back(8'hFF);
        raw.push_back("a");
        push_chars(raw, 1'b0);
        push_text("z.");
        queue_random(20);

        set_limits(8'h00, 8'hFF);   // no label fits, name limit clamps to 253
        queue_random(10);
        set_limits(8'hFF, 8'h00);   // upper bits dropped; no name fits
        queue_random(10);
        set_limits(8'd3, 8'd12);
        queue_random(30);
        set_limits(8'd1, 8'd1);
        queue_random(10);

        // full-size name: 253 characters, a trailing dot, then one too many
        set_limits(8'd63, 8'd253);
        raw = {};
        for (int l = 0; l < 4; l++) begin
            repeat ((l == 3) ? 61 : 63) raw.push_back(alnum());
            raw.push_back(hsc_pkg::CH_DOT);
        end
        raw.push_back("a");
        push_chars(raw, 1'b0);
        queue_random(5);

        set_limits(8'h85, 8'd254);
        queue_random(15);
        set_limits(8'($urandom_range(0, 255)), 8'($urandom_range(1, 40)));
        queue_random(15);

        while (busy()) @(negedge i_clk);
        repeat (6) @(posedge i_clk);
        $display("Sent %0d characters in %0d names under %0d limit settings, %0d results seen.",
                 n_sent, n_names, n_settings, n_results);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
